>>> design/qts_pkg.sv
// Shared types and character constants for the quoted token scanner.
package qts_pkg;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic       emit_valid;
      logic [7:0] emit_byte;
      logic       token_done;
      logic [1:0] token_status;
   } rsp_type;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_TOKEN = 3'd1,
      MODE_ESC   = 3'd2,
      MODE_OCT1  = 3'd3,
      MODE_OCT2  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_ESCAPE = 2'd1,
      ST_NO_TOKEN   = 2'd2
   } status_type;

   typedef struct packed {
      mode_type   scan_mode;
      logic       closing_quote_is_double;
      logic       in_quoted;
      logic [5:0] octal_partial;
   } state_type;

   localparam state_type STATE_IDLE = '{
      scan_mode:               MODE_IDLE,
      closing_quote_is_double: 1'b0,
      in_quoted:               1'b0,
      octal_partial:           6'd0
   };

   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_SEVEN     = 8'h37;

endpackage

>>> design/quoted_token_scanner_top.sv
// Quoted token scanner: splits a text byte stream into tokens, one byte per request.
//
// Channels: req_ carries one text byte and an end-of-data flag per request;
// rsp_ returns exactly one result per request, in order: an optional token
// character, a token-done flag and a status (ok, bad or cut escape, no token).
// Both channels use valid/ready; a transfer happens when both are high.
//
// Latency: a result appears on rsp_ the cycle after its request is taken.
// Throughput: one request per cycle unless rsp_ready stalls; the scan state update
// and the result decode fit between the scan state register and the result register.
// req_ready stays high while the result register is empty or being drained,
// so a waiting result does not block the next request unless rsp_ready is low.
// When the receiver stalls, the result holds and req_ready drops until it is
// taken. After a request with is_last set, the scanner is idle again.
// Reset (synchronous, active high) empties the result register and returns
// the scanner to idle, skipping whitespace.
module quoted_token_scanner_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qts_pkg::rsp_type rsp_data
);

   qts_pkg::state_type state_ff;
   qts_pkg::state_type state_in;
   qts_pkg::rsp_type   rsp_ff;
   qts_pkg::rsp_type   rsp_in;
   logic               rsp_valid_ff;
   logic               req_take;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   qts_step u_step (
      .state      (state_ff),
      .req        (req_data),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qts_pkg::STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
   end

   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      req_take && req_data.is_last |=> state_ff.scan_mode == qts_pkg::MODE_IDLE)
      else $error("scanner not idle after final byte");

   a_take_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted request produced no result");

   a_status_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.token_done |-> rsp_ff.token_status == qts_pkg::ST_OK)
      else $error("nonzero status without token end");

   a_byte_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.emit_valid |-> rsp_ff.emit_byte == 8'd0)
      else $error("emit byte set without emit valid");

   a_partial_only_in_octal: assert property (@(posedge clock) disable iff (reset)
      state_ff.scan_mode != qts_pkg::MODE_OCT1 &&
      state_ff.scan_mode != qts_pkg::MODE_OCT2 |-> state_ff.octal_partial == 6'd0)
      else $error("octal digits held outside an escape");

endmodule

>>> design/qts_step.sv
// One scanner step: result and next state for one request byte.
module qts_step (
   input  qts_pkg::state_type state,
   input  qts_pkg::req_type   req,
   output qts_pkg::state_type state_next,
   output qts_pkg::rsp_type   rsp
);

   logic       is_space;
   logic       is_octal;
   logic       is_quote;
   logic       tb_quoted;
   logic       tb_end;
   logic [2:0] digit;
   logic [7:0] b;
   logic       last;
   logic       done;
   logic [1:0] status;
   logic [8:0] oct_full;

   assign b        = req.byte_in;
   assign last     = req.is_last;
   assign is_space = (b == qts_pkg::CH_SPACE) || (b == qts_pkg::CH_TAB) ||
                     (b == qts_pkg::CH_CR) || (b == qts_pkg::CH_LF);
   assign is_octal = (b >= qts_pkg::CH_ZERO) && (b <= qts_pkg::CH_SEVEN);
   assign is_quote = (b == qts_pkg::CH_DQUOTE) || (b == qts_pkg::CH_SQUOTE);
   assign digit    = b[2:0];
   assign oct_full = {state.octal_partial, digit};

   // Quoting only counts inside a token; a fresh bare token starts unquoted.
   assign tb_quoted = (state.scan_mode == qts_pkg::MODE_TOKEN) && state.in_quoted;
   assign tb_end    = tb_quoted ?
                      (b == (state.closing_quote_is_double ? qts_pkg::CH_DQUOTE
                                                           : qts_pkg::CH_SQUOTE))
                      : is_space;

   // Outputs
   always_comb begin
      rsp.emit_valid = 1'b0;
      rsp.emit_byte  = 8'd0;
      done           = 1'b0;
      status         = qts_pkg::ST_OK;
      case (state.scan_mode)
         qts_pkg::MODE_ESC: begin
            if (is_octal) begin
               done   = last;
               status = qts_pkg::ST_BAD_ESCAPE;
            end else begin
               rsp.emit_valid = 1'b1;
               rsp.emit_byte  = b;
               done           = last;
            end
         end
         qts_pkg::MODE_OCT1: begin
            done   = is_octal ? last : 1'b1;
            status = qts_pkg::ST_BAD_ESCAPE;
         end
         qts_pkg::MODE_OCT2: begin
            if (is_octal) begin
               rsp.emit_valid = 1'b1;
               rsp.emit_byte  = oct_full[7:0];
               done           = last;
            end else begin
               done   = 1'b1;
               status = qts_pkg::ST_BAD_ESCAPE;
            end
         end
         qts_pkg::MODE_TOKEN: begin
            if (tb_end) begin
               done = 1'b1;
            end else if (b == qts_pkg::CH_BACKSLASH) begin
               done   = last;
               status = qts_pkg::ST_BAD_ESCAPE;
            end else begin
               rsp.emit_valid = 1'b1;
               rsp.emit_byte  = b;
               done           = last;
            end
         end
         default: begin
            if (is_space) begin
               done   = last;
               status = qts_pkg::ST_NO_TOKEN;
            end else if (is_quote) begin
               done = last;
            end else if (b == qts_pkg::CH_BACKSLASH) begin
               done   = last;
               status = qts_pkg::ST_BAD_ESCAPE;
            end else begin
               rsp.emit_valid = 1'b1;
               rsp.emit_byte  = b;
               done           = last;
            end
         end
      endcase
      rsp.token_done   = done;
      rsp.token_status = done ? status : qts_pkg::ST_OK;
   end

   // Next state
   always_comb begin
      state_next = state;
      if (done) begin
         state_next = qts_pkg::STATE_IDLE;
      end else begin
         case (state.scan_mode)
            qts_pkg::MODE_ESC: begin
               if (is_octal) begin
                  state_next.scan_mode     = qts_pkg::MODE_OCT1;
                  state_next.octal_partial = {3'd0, digit};
               end else begin
                  state_next.scan_mode = qts_pkg::MODE_TOKEN;
               end
            end
            qts_pkg::MODE_OCT1: begin
               state_next.scan_mode     = qts_pkg::MODE_OCT2;
               state_next.octal_partial = {state.octal_partial[2:0], digit};
            end
            qts_pkg::MODE_OCT2: begin
               state_next.scan_mode     = qts_pkg::MODE_TOKEN;
               state_next.octal_partial = 6'd0;
            end
            qts_pkg::MODE_TOKEN: begin
               state_next.scan_mode = (b == qts_pkg::CH_BACKSLASH) ?
                                      qts_pkg::MODE_ESC : qts_pkg::MODE_TOKEN;
            end
            default: begin
               state_next = qts_pkg::STATE_IDLE;
               if (is_quote) begin
                  state_next.scan_mode               = qts_pkg::MODE_TOKEN;
                  state_next.in_quoted               = 1'b1;
                  state_next.closing_quote_is_double = (b == qts_pkg::CH_DQUOTE);
               end else if (!is_space) begin
                  state_next.scan_mode = (b == qts_pkg::CH_BACKSLASH) ?
                                         qts_pkg::MODE_ESC : qts_pkg::MODE_TOKEN;
               end
            end
         endcase
      end
   end

endmodule

>>> tb/tb_top.sv
// Testbench for the quoted token scanner: directed byte table, then random text.
`timescale 1ns / 100ps

module tb_top;

   localparam int RANDOM_BYTES   = 1530;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 80;

   typedef struct packed {
      qts_pkg::req_type rq;
      logic             typed;
      qts_pkg::rsp_type rsp;
   } directed_row_type;

   localparam qts_pkg::rsp_type NONE = '0;

   // Rows with typed=1 carry a result read straight off the scan rules.
   localparam directed_row_type DIRECTED_ROWS [0:25] = '{
      '{'{qts_pkg::CH_SPACE,     1'b1}, 1'b1, '{1'b0, 8'h00, 1'b1, qts_pkg::ST_NO_TOKEN}},
      '{'{qts_pkg::CH_DQUOTE,    1'b1}, 1'b1, '{1'b0, 8'h00, 1'b1, qts_pkg::ST_OK}},
      '{'{8'h00,                 1'b0}, 1'b1, '{1'b1, 8'h00, 1'b0, qts_pkg::ST_OK}},
      '{'{8'hFF,                 1'b0}, 1'b1, '{1'b1, 8'hFF, 1'b0, qts_pkg::ST_OK}},
      '{'{qts_pkg::CH_LF,        1'b0}, 1'b1, '{1'b0, 8'h00, 1'b1, qts_pkg::ST_OK}},
      '{'{qts_pkg::CH_SQUOTE,    1'b0}, 1'b0, NONE},
      '{'{qts_pkg::CH_SPACE,     1'b0}, 1'b0, NONE},
      '{'{qts_pkg::CH_DQUOTE,    1'b0}, 1'b0, NONE},
      '{'{qts_pkg::CH_BACKSLASH, 1'b0}, 1'b0, NONE},
      '{'{qts_pkg::CH_SQUOTE,    1'b0}, 1'b0, NONE},
      '{'{qts_pkg::CH_BACKSLASH, 1'b0}, 1'b0, NONE},
      '{'{qts_pkg::CH_SEVEN,     1'b0}, 1'b0, NONE},
      '{'{qts_pkg::CH_SEVEN,     1'b0}, 1'b0, NONE},
      '{'{qts_pkg::CH_SEVEN,     1'b0}, 1'b0, NONE},
      '{'{qts_pkg::CH_SQUOTE,    1'b0}, 1'b0, NONE},
      '{'{8'h41,                 1'b0}, 1'b0, NONE},
      '{'{qts_pkg::CH_BACKSLASH, 1'b0}, 1'b0, NONE},
      '{'{qts_pkg::CH_ZERO,      1'b0}, 1'b0, NONE},
      '{'{8'h38,                 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b1, qts_pkg::ST_BAD_ESCAPE}},
      '{'{8'h62,                 1'b0}, 1'b0, NONE},
      '{'{qts_pkg::CH_BACKSLASH, 1'b1}, 1'b1, '{1'b0, 8'h00, 1'b1, qts_pkg::ST_BAD_ESCAPE}},
      '{'{8'h7A,                 1'b1}, 1'b1, '{1'b1, 8'h7A, 1'b1, qts_pkg::ST_OK}},
      '{'{qts_pkg::CH_BACKSLASH, 1'b0}, 1'b0, NONE},
      '{'{qts_pkg::CH_ZERO,      1'b1}, 1'b1, '{1'b0, 8'h00, 1'b1, qts_pkg::ST_BAD_ESCAPE}},
      '{'{8'h64,                 1'b0}, 1'b0, NONE},
      '{'{qts_pkg::CH_CR,        1'b1}, 1'b1, '{1'b0, 8'h00, 1'b1, qts_pkg::ST_OK}}
   };

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   qts_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   qts_pkg::rsp_type rsp_data;

   qts_pkg::state_type scan_state = qts_pkg::STATE_IDLE;
   qts_pkg::rsp_type   results_due [$];
   qts_pkg::req_type   pending_text [$];

   int sender_idle_pct   = 8;
   int receiver_idle_pct = 76;
   bit hold_off_request  = 1'b0;
   int failures          = 0;
   int bytes_sent        = 0;
   int chars_emitted     = 0;
   int ends_ok           = 0;
   int ends_bad          = 0;
   int ends_empty        = 0;

   quoted_token_scanner_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   function automatic logic is_space(logic [7:0] b);
      return b == qts_pkg::CH_SPACE || b == qts_pkg::CH_TAB ||
             b == qts_pkg::CH_CR || b == qts_pkg::CH_LF;
   endfunction

   function automatic logic is_octal(logic [7:0] b);
      return b >= qts_pkg::CH_ZERO && b <= qts_pkg::CH_SEVEN;
   endfunction

   // Build a result; a finished token drops the scanner back to idle.
   function automatic qts_pkg::rsp_type close_result(logic valid, logic [7:0] b, logic done,
                                                     qts_pkg::status_type st);
      qts_pkg::rsp_type r;
      r.emit_valid   = valid;
      r.emit_byte    = valid ? b : 8'h00;
      r.token_done   = done;
      r.token_status = done ? st : qts_pkg::ST_OK;
      if (done) scan_state = qts_pkg::STATE_IDLE;
      return r;
   endfunction

   function automatic qts_pkg::rsp_type token_char(logic [7:0] b, logic fin);
      logic [7:0] closing;
      closing = scan_state.closing_quote_is_double ? qts_pkg::CH_DQUOTE : qts_pkg::CH_SQUOTE;
      if (scan_state.in_quoted ? (b == closing) : is_space(b))
         return close_result(1'b0, 8'h00, 1'b1, qts_pkg::ST_OK);
      if (b == qts_pkg::CH_BACKSLASH) begin
         scan_state.scan_mode = qts_pkg::MODE_ESC;
         return close_result(1'b0, 8'h00, fin, qts_pkg::ST_BAD_ESCAPE);
      end
      scan_state.scan_mode = qts_pkg::MODE_TOKEN;
      return close_result(1'b1, b, fin, qts_pkg::ST_OK);
   endfunction

   function automatic qts_pkg::rsp_type scan_byte(qts_pkg::req_type rq);
      logic [7:0] b;
      logic       fin;
      logic [7:0] octal_value;
      b   = rq.byte_in;
      fin = rq.is_last;
      case (scan_state.scan_mode)
         qts_pkg::MODE_TOKEN: return token_char(b, fin);
         qts_pkg::MODE_ESC: begin
            if (!is_octal(b)) begin
               scan_state.scan_mode = qts_pkg::MODE_TOKEN;
               return close_result(1'b1, b, fin, qts_pkg::ST_OK);
            end
            scan_state.octal_partial = {3'b000, b[2:0]};
            scan_state.scan_mode     = qts_pkg::MODE_OCT1;
            return close_result(1'b0, 8'h00, fin, qts_pkg::ST_BAD_ESCAPE);
         end
         qts_pkg::MODE_OCT1: begin
            if (!is_octal(b))
               return close_result(1'b0, 8'h00, 1'b1, qts_pkg::ST_BAD_ESCAPE);
            scan_state.octal_partial = {scan_state.octal_partial[2:0], b[2:0]};
            scan_state.scan_mode     = qts_pkg::MODE_OCT2;
            return close_result(1'b0, 8'h00, fin, qts_pkg::ST_BAD_ESCAPE);
         end
         qts_pkg::MODE_OCT2: begin
            if (!is_octal(b))
               return close_result(1'b0, 8'h00, 1'b1, qts_pkg::ST_BAD_ESCAPE);
            // third digit: keep the low 8 bits of the octal value
            octal_value              = {scan_state.octal_partial[4:0], b[2:0]};
            scan_state.octal_partial = '0;
            scan_state.scan_mode     = qts_pkg::MODE_TOKEN;
            return close_result(1'b1, octal_value, fin, qts_pkg::ST_OK);
         end
         default: begin
            scan_state = qts_pkg::STATE_IDLE;
            if (is_space(b)) return close_result(1'b0, 8'h00, fin, qts_pkg::ST_NO_TOKEN);
            if (b == qts_pkg::CH_DQUOTE || b == qts_pkg::CH_SQUOTE) begin
               scan_state.in_quoted               = 1'b1;
               scan_state.closing_quote_is_double = (b == qts_pkg::CH_DQUOTE);
               scan_state.scan_mode               = qts_pkg::MODE_TOKEN;
               return close_result(1'b0, 8'h00, fin, qts_pkg::ST_OK);
            end
            return token_char(b, fin);
         end
      endcase
   endfunction

   function automatic void add_text(logic [7:0] b, logic fin = 1'b0);
      pending_text.push_back('{b, fin});
   endfunction

   function automatic logic [7:0] space_char();
      case ($urandom_range(0, 3))
         0: return qts_pkg::CH_SPACE;
         1: return qts_pkg::CH_TAB;
         2: return qts_pkg::CH_CR;
         default: return qts_pkg::CH_LF;
      endcase
   endfunction

   // A byte with no special meaning at this point of a token.
   function automatic logic [7:0] plain_char(logic quoted, logic dq, logic first);
      logic [7:0] b;
      logic       reject;
      do begin
         b      = 8'($urandom_range(0, 255));
         reject = b == qts_pkg::CH_BACKSLASH
                  || (quoted ? b == (dq ? qts_pkg::CH_DQUOTE : qts_pkg::CH_SQUOTE)
                             : is_space(b))
                  || (first && (b == qts_pkg::CH_DQUOTE || b == qts_pkg::CH_SQUOTE));
      end while (reject);
      return b;
   endfunction

   function automatic logic [7:0] octal_digit();
      return qts_pkg::CH_ZERO + 8'($urandom_range(0, 7));
   endfunction

   function automatic void add_body_char(logic quoted, logic dq);
      case ($urandom_range(0, 9))
         6, 7: begin
            add_text(qts_pkg::CH_BACKSLASH);
            repeat (3) add_text(octal_digit());
         end
         8: begin
            add_text(qts_pkg::CH_BACKSLASH);
            add_text(8'($urandom_range(0, 255)));
         end
         default: add_text(plain_char(quoted, dq, 1'b0));
      endcase
   endfunction

   function automatic void mark_end();
      qts_pkg::req_type tail;
      tail         = pending_text.pop_back();
      tail.is_last = 1'b1;
      pending_text.push_back(tail);
   endfunction

   // Refill with mostly well-formed data, some noise and some broken escapes.
   function automatic void refill_text();
      int   tokens;
      logic quoted;
      logic dq;
      logic [7:0] b;
      case ($urandom_range(0, 9))
         7, 8: begin
            repeat ($urandom_range(1, 12))
               add_text(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end
         9: begin
            add_text(plain_char(1'b0, 1'b0, 1'b1));
            add_text(qts_pkg::CH_BACKSLASH);
            repeat ($urandom_range(0, 2)) add_text(octal_digit());
            if ($urandom_range(0, 1)) begin
               do b = 8'($urandom_range(0, 255)); while (is_octal(b));
               add_text(b, $urandom_range(0, 3) == 0);
            end else begin
               mark_end();
            end
         end
         default: begin
            tokens = $urandom_range(0, 4);
            repeat ($urandom_range(0, 2)) add_text(space_char());
            for (int t = 0; t < tokens; t++) begin
               quoted = $urandom_range(0, 2) == 0;
               dq     = $urandom_range(0, 1);
               if (quoted) begin
                  add_text(dq ? qts_pkg::CH_DQUOTE : qts_pkg::CH_SQUOTE);
                  repeat ($urandom_range(0, 6)) add_body_char(1'b1, dq);
                  // leave the last quote open now and then
                  if (t != tokens - 1 || $urandom_range(0, 5) != 0)
                     add_text(dq ? qts_pkg::CH_DQUOTE : qts_pkg::CH_SQUOTE);
                  repeat ($urandom_range(0, 1)) add_text(space_char());
               end else begin
                  add_text(plain_char(1'b0, 1'b0, 1'b1));
                  repeat ($urandom_range(0, 5)) add_body_char(1'b0, 1'b0);
                  if (t != tokens - 1)
                     repeat ($urandom_range(1, 2)) add_text(space_char());
               end
            end
            repeat ($urandom_range(0, 2)) add_text(space_char());
            if (pending_text.size() == 0) add_text(space_char());
            mark_end();
         end
      endcase
   endfunction

   task automatic send_request(qts_pkg::req_type rq, logic use_typed,
                               qts_pkg::rsp_type typed_rsp);
      qts_pkg::rsp_type predicted;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
      predicted = scan_byte(rq);
      results_due.push_back(use_typed ? typed_rsp : predicted);
      bytes_sent++;
   endtask

   // Receiver: check each result, then drive ready for the next cycle.
   initial begin
      qts_pkg::rsp_type want;
      int               hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (rsp_data.emit_valid) chars_emitted++;
            if (rsp_data.token_done) begin
               if (rsp_data.token_status == qts_pkg::ST_OK) ends_ok++;
               else if (rsp_data.token_status == qts_pkg::ST_BAD_ESCAPE) ends_bad++;
               else ends_empty++;
            end
            if (results_due.size() == 0) begin
               $error("result %h arrived with no request outstanding", rsp_data);
               failures++;
            end else begin
               want = results_due.pop_front();
               if (rsp_data.emit_valid !== want.emit_valid) begin
                  $error("emit_valid: expected %0b, got %0b", want.emit_valid,
                         rsp_data.emit_valid);
                  failures++;
               end
               if (rsp_data.emit_byte !== want.emit_byte) begin
                  $error("emit_byte: expected %h, got %h", want.emit_byte, rsp_data.emit_byte);
                  failures++;
               end
               if (rsp_data.token_done !== want.token_done) begin
                  $error("token_done: expected %0b, got %0b", want.token_done,
                         rsp_data.token_done);
                  failures++;
               end
               if (rsp_data.token_status !== want.token_status) begin
                  $error("token_status: expected %0d, got %0d", want.token_status,
                         rsp_data.token_status);
                  failures++;
               end
            end
         end
         if (hold_off_request) begin
            hold_left        = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
      end
   end

   // Watchdog: end the run when neither channel moves for too long.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
               $display("tb_top failed");
               $finish;
            end
         end
      end
   end

   initial begin
      int random_sent;
      random_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         send_request(DIRECTED_ROWS[i].rq, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rsp);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 8;  receiver_idle_pct = 76; end
            1: begin sender_idle_pct = 76; receiver_idle_pct = 8;  end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
               // stall the receiver while requests keep coming
               hold_off_request  = 1'b1;
            end
         endcase
         while (random_sent < RANDOM_BYTES * (phase + 1) / 3) begin
            if (pending_text.size() == 0) refill_text();
            send_request(pending_text.pop_front(), 1'b0, NONE);
            random_sent++;
         end
      end
      req_valid <= 1'b0;

      while (results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d bytes (%0d from the directed table) under three idle patterns",
               bytes_sent, $size(DIRECTED_ROWS));
      $display("and one long receiver hold-off; ends: %0d ok, %0d bad escape, %0d empty; %0d chars.",
               ends_ok, ends_bad, ends_empty, chars_emitted);
      if (failures == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

>>> files.f
design/qts_pkg.sv
design/qts_step.sv
design/quoted_token_scanner_top.sv
tb/tb_top.sv
